/* hdl/usm_pkg.sv */
package usm_pkg;

    localparam int SECTORS_DEF     = 192;
    localparam int STACKS_DEF      = 192;
    localparam int ANGLE_STEPS_DEF = 384;

    localparam int RADIUS_W     = 16;
    localparam int COORD_W      = 8;
    localparam int POS_W        = 16;
    localparam int TEX_W        = 18;
    localparam int IDX_W        = 18;
    localparam int Q15_W        = 16;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd2560;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    // Q2.30 constants and sine ROM generation (elaboration only).
    localparam longint unsigned Q30_ONE    = 64'd1073741824;
    localparam longint unsigned HALFPI_Q30 = 64'd1686629713;

    function automatic longint unsigned poly_sin(input longint unsigned x);
        longint unsigned x2, t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

    function automatic longint unsigned poly_cos(input longint unsigned x);
        longint unsigned x2, t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 56;
        t  = Q30_ONE - ((x2 * t) >> 30) / 30;
        t  = Q30_ONE - ((x2 * t) >> 30) / 12;
        t  = Q30_ONE - ((x2 * t) >> 30) / 2;
        return t;
    endfunction

    function automatic longint unsigned to_q15(input longint unsigned v);
        longint unsigned r;
        r = (v + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r;
    endfunction

    // Signed Q1.15 sine (want_cos=0) or cosine of a Q2.30 angle in [0, 2*pi).
    function automatic logic signed [Q15_W-1:0] rom_trig(input longint unsigned ang,
                                                          input bit want_cos);
        longint unsigned th, s0, c0;
        int q;
        longint signed rs, rc;
        th = ang;
        q  = 0;
        while (th >= HALFPI_Q30 && q < 3) begin
            th = th - HALFPI_Q30;
            q  = q + 1;
        end
        if (th > HALFPI_Q30) begin
            th = HALFPI_Q30;
        end
        if (th <= HALFPI_Q30 / 2) begin
            s0 = to_q15(poly_sin(th));
            c0 = to_q15(poly_cos(th));
        end else begin
            s0 = to_q15(poly_cos(HALFPI_Q30 - th));
            c0 = to_q15(poly_sin(HALFPI_Q30 - th));
        end
        case (q)
            0: begin rs = s0;  rc = c0;  end
            1: begin rs = c0;  rc = -s0; end
            2: begin rs = -s0; rc = -c0; end
            default: begin rs = -c0; rc = s0; end
        endcase
        return want_cos ? rc[Q15_W-1:0] : rs[Q15_W-1:0];
    endfunction

    // Controller to datapath.
    typedef struct packed {
        logic       load;      // latch cell, start first record
        logic       advance;   // next record
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic       rec_done;  // current record result registered
    } t_status;

endpackage

/* hdl/usm_if.sv */
interface usm_cell_if;
    logic       valid;
    logic       ready;
    logic [7:0] stack_row;
    logic [7:0] sector_col;
    logic       restart;
    modport source (output valid, stack_row, sector_col, restart, input ready);
    modport sink   (input valid, stack_row, sector_col, restart, output ready);
endinterface

interface usm_rec_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [17:0]        tex_u;
    logic [17:0]        tex_v;
    logic [17:0]        index_value;
    logic               last;
    modport source (output valid, kind, pos_x, pos_y, pos_z, tex_u, tex_v, index_value,
                    last, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, pos_z, tex_u, tex_v, index_value,
                    last, output ready);
endinterface

interface usm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* hdl/uv_sphere_mesh_generator.sv */
// UV sphere cell tessellator.
// Channels: cell_in (stack_row, sector_col, restart) in, rec_out (one vertex or
// index record per beat) out, cfg (sphere radius, Q8.8) in. A beat moves when
// valid and ready are both high.
// Each cell gives 6 records (top or bottom row) or 10 (other rows): vertices
// first, then indices; last marks the final record of the cell.
// After the cell beat the first record goes through table lookup, radius
// product and xy product into the output register before it is valid. Each
// further record runs the same steps once the previous one is taken. One cell
// in flight at a time; cells outside the grid are taken while idle and give
// no records (restart still clears the counter).
// Stall: rec_out holds its record while ready is low and no further work runs.
// Reset (synchronous, active low): vertex counter cleared, radius 10.0,
// no record pending. cfg is always ready.
module uv_sphere_mesh_generator #(
    parameter int SECTORS     = usm_pkg::SECTORS_DEF,
    parameter int STACKS      = usm_pkg::STACKS_DEF,
    parameter int ANGLE_STEPS = usm_pkg::ANGLE_STEPS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    usm_cell_if.sink   cell_in,
    usm_rec_if.source  rec_out,
    usm_cfg_if.sink    cfg
);

    usm_pkg::t_cmd    cmd;
    usm_pkg::t_status status;
    logic             cell_ok, last_rec;
    logic [15:0]      r_radius;

    // Radius register
    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= usm_pkg::RADIUS_RESET;
        end else if (cfg.valid) begin
            r_radius <= cfg.data;
        end
    end

    usm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (cell_in.valid),
        .o_in_ready  (cell_in.ready),
        .i_cell_ok   (cell_ok),
        .i_last_rec  (last_rec),
        .i_status    (status),
        .o_out_valid (rec_out.valid),
        .i_out_ready (rec_out.ready),
        .o_cmd       (cmd)
    );

    usm_datapath #(
        .SECTORS     (SECTORS),
        .STACKS      (STACKS),
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_stack_row   (cell_in.stack_row),
        .i_sector_col  (cell_in.sector_col),
        .i_restart     (cell_in.restart),
        .i_radius      (r_radius),
        .o_cell_ok     (cell_ok),
        .o_last_rec    (last_rec),
        .o_kind        (rec_out.kind),
        .o_pos_x       (rec_out.pos_x),
        .o_pos_y       (rec_out.pos_y),
        .o_pos_z       (rec_out.pos_z),
        .o_tex_u       (rec_out.tex_u),
        .o_tex_v       (rec_out.tex_v),
        .o_index_value (rec_out.index_value),
        .o_last        (rec_out.last)
    );

endmodule

/* hdl/usm_ctrl.sv */
module usm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cell_ok,
    input  logic               i_last_rec,
    input  usm_pkg::t_status   i_status,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output usm_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_SEND = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_cell_ok) begin
                        n_state = S_CALC;
                    end
                end
            end
            S_CALC: begin
                if (i_status.rec_done) begin
                    n_state = S_SEND;
                end
            end
            S_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_last_rec) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state = S_CALC;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/usm_datapath.sv */
module usm_datapath #(
    parameter int SECTORS     = usm_pkg::SECTORS_DEF,
    parameter int STACKS      = usm_pkg::STACKS_DEF,
    parameter int ANGLE_STEPS = usm_pkg::ANGLE_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  usm_pkg::t_cmd        i_cmd,
    output usm_pkg::t_status     o_status,
    input  logic [7:0]           i_stack_row,
    input  logic [7:0]           i_sector_col,
    input  logic                 i_restart,
    input  logic [15:0]          i_radius,
    output logic                 o_cell_ok,
    output logic                 o_last_rec,
    output logic                 o_kind,
    output logic signed [15:0]   o_pos_x,
    output logic signed [15:0]   o_pos_y,
    output logic signed [15:0]   o_pos_z,
    output logic [17:0]          o_tex_u,
    output logic [17:0]          o_tex_v,
    output logic [17:0]          o_index_value,
    output logic                 o_last
);

    localparam int ROWS_N = STACKS + 1;   // rows 0..STACKS
    localparam int COLS_N = SECTORS + 1;  // columns 0..SECTORS
    localparam int RW     = $clog2(ROWS_N);
    localparam int CW     = $clog2(COLS_N);
    localparam int IW     = usm_pkg::IDX_W;

    // Per-row and per-column tables, built at elaboration.
    typedef logic signed [15:0] t_q15;
    typedef logic [17:0]        t_tex;

    t_q15 row_sin [ROWS_N];
    t_q15 row_cos [ROWS_N];
    t_tex row_v   [ROWS_N];
    t_q15 col_sin [COLS_N];
    t_q15 col_cos [COLS_N];
    t_tex col_u   [COLS_N];

    for (genvar g = 0; g < ROWS_N; g++) begin : g_row
        localparam int PH = (g * ANGLE_STEPS + STACKS) / (2 * STACKS);
        localparam longint unsigned TH =
            longint'(PH % ANGLE_STEPS) * 4 * usm_pkg::HALFPI_Q30 / longint'(ANGLE_STEPS);
        localparam longint unsigned TV = (longint'(g + 1) * 131072 + STACKS) / (2 * STACKS);
        assign row_sin[g] = usm_pkg::rom_trig(TH, 1'b0);
        assign row_cos[g] = usm_pkg::rom_trig(TH, 1'b1);
        assign row_v[g]   = 18'(TV);
    end
    for (genvar g = 0; g < COLS_N; g++) begin : g_col
        localparam int PH = (g * 2 * ANGLE_STEPS + SECTORS) / (2 * SECTORS);
        localparam longint unsigned TH =
            longint'(PH % ANGLE_STEPS) * 4 * usm_pkg::HALFPI_Q30 / longint'(ANGLE_STEPS);
        localparam longint unsigned TU = (longint'(g + 1) * 131072 + SECTORS) / (2 * SECTORS);
        assign col_sin[g] = usm_pkg::rom_trig(TH, 1'b0);
        assign col_cos[g] = usm_pkg::rom_trig(TH, 1'b1);
        assign col_u[g]   = 18'(TU);
    end

    // Cell registers
    logic [RW-1:0] r_s;
    logic [CW-1:0] r_c;
    logic [1:0]    r_shape;   // 0 top, 1 bottom, 2 middle
    logic [IW-1:0] r_cnt, r_base;
    logic [3:0]    r_rec;
    logic [2:0]    r_phase;

    logic [IW-1:0] cnt_now;
    assign cnt_now   = i_restart ? '0 : r_cnt;
    assign o_cell_ok = (32'(i_stack_row) < STACKS) && (32'(i_sector_col) < SECTORS);

    logic [2:0] nv;
    assign nv = (r_shape == 2'd2) ? 3'd4 : 3'd3;
    logic [3:0] n_total;
    assign n_total = (r_shape == 2'd2) ? 4'd10 : 4'd6;
    assign o_last_rec = (r_rec == n_total - 4'd1);

    // Record decode
    logic          is_vtx;
    logic [1:0]    corner;
    logic [1:0]    offs;
    logic          ds, dc;
    always_comb begin
        is_vtx = (r_rec < {1'b0, nv});
        corner = r_rec[1:0];
        offs   = 2'd0;
        if (!is_vtx) begin
            case (r_rec - {1'b0, nv})
                4'd0:    offs = 2'd0;
                4'd1:    offs = 2'd1;
                4'd2:    offs = 2'd2;
                4'd3:    offs = 2'd2;
                4'd4:    offs = 2'd1;
                default: offs = 2'd3;
            endcase
        end
        // v1=(s,c) v2=(s+1,c) v3=(s,c+1) v4=(s+1,c+1); top row order v2,v1,v4
        if (r_shape == 2'd0) begin
            case (corner)
                2'd0:    begin ds = 1'b1; dc = 1'b0; end
                2'd1:    begin ds = 1'b0; dc = 1'b0; end
                default: begin ds = 1'b1; dc = 1'b1; end
            endcase
        end else begin
            ds = corner[0];
            dc = corner[1];
        end
    end

    logic [RW-1:0] vs;
    logic [CW-1:0] vc;
    assign vs = r_s + RW'(ds);
    assign vc = r_c + CW'(dc);

    // Signed-magnitude Q15 product, rounded half away from zero.
    function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                                input logic signed [15:0] b);
        logic [33:0] ma;
        logic [15:0] mb;
        logic [49:0] m;
        logic        neg;
        neg = a[33] ^ b[15];
        ma  = a[33] ? -a : a;
        mb  = b[15] ? -b : b;
        m   = ((50'(ma) * 50'(mb)) + 50'd16384) >> 15;
        return neg ? -34'(m) : 34'(m);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767) begin
            return 16'sh7fff;
        end else if (v < -34'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Datapath sequence: phase 0 table lookup, 1 xy and z, 2 x and y.
    t_q15 r_sp, r_cp, r_st, r_ct;
    logic signed [33:0] r_xy, r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_phase <= '0;
        end else begin
            if (i_cmd.load) begin
                r_cnt <= cnt_now;
                if (o_cell_ok) begin
                    r_s     <= i_stack_row[RW-1:0];
                    r_c     <= i_sector_col[CW-1:0];
                    r_base  <= cnt_now;
                    r_rec   <= '0;
                    r_phase <= 3'b001;
                    if (i_stack_row == 8'd0) begin
                        r_shape <= 2'd0;
                        r_cnt   <= cnt_now + IW'(3);
                    end else if (32'(i_stack_row) == STACKS - 1) begin
                        r_shape <= 2'd1;
                        r_cnt   <= cnt_now + IW'(3);
                    end else begin
                        r_shape <= 2'd2;
                        r_cnt   <= cnt_now + IW'(4);
                    end
                end
            end else if (i_cmd.advance) begin
                r_rec   <= r_rec + 4'd1;
                r_phase <= 3'b001;
            end else begin
                r_phase <= {r_phase[1:0], 1'b0};
            end
        end
    end

    assign o_status.rec_done = r_phase[2];

    always_ff @(posedge i_clk) begin
        if (r_phase[0]) begin
            r_sp <= row_sin[vs];
            r_cp <= row_cos[vs];
            r_st <= col_sin[vc];
            r_ct <= col_cos[vc];
        end
        if (r_phase[1]) begin
            r_xy <= mulq(34'(i_radius), r_sp);
            r_z  <= mulq(34'(i_radius), r_cp);
        end
        if (r_phase[2]) begin
            o_kind <= is_vtx ? usm_pkg::KIND_VERTEX : usm_pkg::KIND_INDEX;
            o_last <= o_last_rec;
            if (is_vtx) begin
                o_pos_x       <= sat16(mulq(r_xy, r_ct));
                o_pos_y       <= sat16(mulq(r_xy, r_st));
                o_pos_z       <= sat16(r_z);
                o_tex_u       <= col_u[vc];
                o_tex_v       <= row_v[vs];
                o_index_value <= r_base + IW'(corner);
            end else begin
                o_pos_x       <= '0;
                o_pos_y       <= '0;
                o_pos_z       <= '0;
                o_tex_u       <= '0;
                o_tex_v       <= '0;
                o_index_value <= r_base + IW'(offs);
            end
        end
    end

endmodule

/* hdl/usm_checker.sv */
module usm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_kind,
    input logic       i_out_last,
    input logic [15:0] i_pos_x
);

    // No new cell while a record is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("cell accepted during output");

    // A cell beat is never followed at once by a record.
    a_cell_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_out_valid)
        else $error("record straight after cell beat");

    // Index records carry no position.
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind) |-> (i_pos_x == 16'd0))
        else $error("index record with position");

    // Last record is an index record.
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_last) |-> i_out_kind)
        else $error("last on vertex record");

    // Stalled record holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_last)))
        else $error("stalled record dropped");

endmodule

bind uv_sphere_mesh_generator usm_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (cell_in.valid),
    .i_in_ready  (cell_in.ready),
    .i_out_valid (rec_out.valid),
    .i_out_ready (rec_out.ready),
    .i_out_kind  (rec_out.kind),
    .i_out_last  (rec_out.last),
    .i_pos_x     (rec_out.pos_x)
);

/* sim/uv_sphere_mesh_generator_test.sv */
// Checks the UV sphere cell tessellator against an in-bench predictor.
// A short table of directed cells (poles, grid edges, cells off the grid,
// restarts) is run at the reset radius first. Random cells follow under
// several radius settings, including both extremes. Both channels idle at
// random, first one way, then the other, then not at all.
module uv_sphere_mesh_generator_test;

    localparam int  N_SECT     = usm_pkg::SECTORS_DEF;
    localparam int  N_STACK    = usm_pkg::STACKS_DEF;
    localparam int  N_STEPS    = usm_pkg::ANGLE_STEPS_DEF;
    localparam int  POS_BITS   = usm_pkg::POS_W;
    localparam int  TEX_BITS   = usm_pkg::TEX_W;
    localparam int  IDX_BITS   = usm_pkg::IDX_W;
    localparam int  STALL_MAX  = 5000;   // cycles with no beat on any channel
    localparam int  DRAIN_WAIT = 60;     // covers an off-grid cell and the return to idle
    localparam int  PHASE_LEN  = 58;
    localparam longint unsigned Q30_UNIT = 64'd1073741824;
    localparam longint unsigned QUARTER  = 64'd1686629713;   // pi/2 in Q2.30

    typedef struct {
        logic                       kind;
        logic signed [POS_BITS-1:0] pos_x;
        logic signed [POS_BITS-1:0] pos_y;
        logic signed [POS_BITS-1:0] pos_z;
        logic [TEX_BITS-1:0]        tex_u;
        logic [TEX_BITS-1:0]        tex_v;
        logic [IDX_BITS-1:0]        index_value;
        logic                       last;
    } t_mesh_rec;

    // Directed cell with the record count that can be read straight off its row and column.
    typedef struct {
        int unsigned row;
        int unsigned col;
        bit          restart;
        int          n_recs;
    } t_cell_row;

    logic i_clk;
    logic i_rst_n;

    usm_cell_if cell_bus ();
    usm_rec_if  rec_bus ();
    usm_cfg_if  cfg_bus ();

    uv_sphere_mesh_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cell_in (cell_bus),
        .rec_out (rec_bus),
        .cfg     (cfg_bus)
    );

    // Predictor state
    t_mesh_rec            pending_recs[$];
    logic [IDX_BITS-1:0]  vert_count;
    logic [15:0]          radius_q88;

    int errors;
    int cells_taken;
    int recs_seen;
    int off_grid;
    int restarts;
    int stall_cycles;
    int send_idle_pct;
    int recv_idle_pct;

    t_cell_row directed_cells[] = '{
        '{0,   0,   1'b1, 6},    // north pole row, first column
        '{0,   191, 1'b0, 6},    // north pole row, last column wraps azimuth
        '{191, 0,   1'b0, 6},    // south pole row
        '{191, 191, 1'b0, 6},
        '{1,   0,   1'b0, 10},
        '{190, 191, 1'b0, 10},
        '{96,  96,  1'b0, 10},   // equator
        '{48,  48,  1'b0, 10},
        '{144, 144, 1'b0, 10},
        '{192, 0,   1'b0, 0},    // row just past the grid
        '{0,   192, 1'b0, 0},    // column just past the grid
        '{255, 255, 1'b1, 0},    // off grid, restart still clears the count
        '{0,   0,   1'b0, 6},
        '{5,   255, 1'b0, 0},
        '{255, 5,   1'b0, 0},
        '{100, 47,  1'b1, 10},
        '{10,  95,  1'b0, 10},
        '{10,  143, 1'b0, 10},
        '{50,  100, 1'b0, 10},
        '{120, 180, 1'b0, 10},
        '{170, 170, 1'b1, 10}
    };

    // ---------------- trig table, Q1.15 ----------------

    function automatic longint unsigned taylor_sin(input longint unsigned a);
        longint unsigned a2, t;
        a2 = (a * a) >> 30;
        t  = Q30_UNIT - a2 / 72;
        t  = Q30_UNIT - ((a2 * t) >> 30) / 42;
        t  = Q30_UNIT - ((a2 * t) >> 30) / 20;
        t  = Q30_UNIT - ((a2 * t) >> 30) / 6;
        return (a * t) >> 30;
    endfunction

    function automatic longint unsigned taylor_cos(input longint unsigned a);
        longint unsigned a2, t;
        a2 = (a * a) >> 30;
        t  = Q30_UNIT - a2 / 56;
        t  = Q30_UNIT - ((a2 * t) >> 30) / 30;
        t  = Q30_UNIT - ((a2 * t) >> 30) / 12;
        t  = Q30_UNIT - ((a2 * t) >> 30) / 2;
        return t;
    endfunction

    function automatic longint round_q15(input longint unsigned v);
        longint unsigned r;
        r = (v + 64'd16384) >> 15;
        return (r > 64'd32767) ? 32767 : longint'(r);
    endfunction

    function automatic void phase_sincos(input longint unsigned phase,
                                         output longint sn, output longint cs);
        longint unsigned ang;
        longint          s0, c0;
        int              quad;
        ang  = (phase % N_STEPS) * 4 * QUARTER / N_STEPS;
        quad = 0;
        while (ang >= QUARTER && quad < 3) begin
            ang  = ang - QUARTER;
            quad = quad + 1;
        end
        if (ang > QUARTER) begin
            ang = QUARTER;
        end
        // fold onto the nearer half of the quadrant
        if (ang <= QUARTER / 2) begin
            s0 = round_q15(taylor_sin(ang));
            c0 = round_q15(taylor_cos(ang));
        end else begin
            s0 = round_q15(taylor_cos(QUARTER - ang));
            c0 = round_q15(taylor_sin(QUARTER - ang));
        end
        case (quad)
            0:       begin sn = s0;  cs = c0;  end
            1:       begin sn = c0;  cs = -s0; end
            2:       begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0;  end
        endcase
    endfunction

    // Sign-magnitude product, >>15 rounded half away from zero.
    function automatic longint q15_product(input longint a, input longint b);
        longint unsigned ma, mb, m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m  = (ma * mb + 64'd16384) >> 15;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [POS_BITS-1:0] clamp16(input longint v);
        if (v > 32767) begin
            return 16'sd32767;
        end
        if (v < -32768) begin
            return -16'sd32768;
        end
        return v[POS_BITS-1:0];
    endfunction

    function automatic t_mesh_rec corner_vertex(input int unsigned row, input int unsigned col,
                                                input logic [IDX_BITS-1:0] idx);
        t_mesh_rec       r;
        longint          sp, cp, st, ct, xy;
        longint unsigned ph_lat, ph_lon;
        ph_lat = (longint'(row) * N_STEPS + N_STACK) / (2 * N_STACK);
        ph_lon = (longint'(col) * 2 * N_STEPS + N_SECT) / (2 * N_SECT);
        phase_sincos(ph_lat, sp, cp);
        phase_sincos(ph_lon, st, ct);
        xy            = q15_product(longint'(radius_q88), sp);   // full width, no clamp
        r.kind        = usm_pkg::KIND_VERTEX;
        r.pos_x       = clamp16(q15_product(xy, ct));
        r.pos_y       = clamp16(q15_product(xy, st));
        r.pos_z       = clamp16(q15_product(longint'(radius_q88), cp));
        r.tex_u       = TEX_BITS'(((longint'(col) + 1) * 131072 + N_SECT) / (2 * N_SECT));
        r.tex_v       = TEX_BITS'(((longint'(row) + 1) * 131072 + N_STACK) / (2 * N_STACK));
        r.index_value = idx;
        r.last        = 1'b0;
        return r;
    endfunction

    // Appends one expected record to the tail of the queue.
    function automatic void queue_expected(input t_mesh_rec r);
        pending_recs = {pending_recs, r};
    endfunction

    // Expected records of one accepted cell; returns how many were queued.
    function automatic int predict_cell(input int unsigned row, input int unsigned col,
                                        input bit restart);
        t_mesh_rec           recs[10];
        int unsigned         vr[4], vc[4];
        int                  offs[6];
        int                  nv, ni;
        logic [IDX_BITS-1:0] base;
        if (restart) begin
            vert_count = '0;
        end
        if (row >= N_STACK || col >= N_SECT) begin
            return 0;
        end
        base = vert_count;
        if (row == 0) begin
            // north pole: lower corner (row + 1) first, then upper, then lower
            vr = '{row + 1, row, row + 1, 0};
            vc = '{col, col, col + 1, 0};
            nv = 3;
        end else if (row == N_STACK - 1) begin
            vr = '{row, row + 1, row, 0};
            vc = '{col, col, col + 1, 0};
            nv = 3;
        end else begin
            vr = '{row, row + 1, row, row + 1};
            vc = '{col, col, col + 1, col + 1};
            nv = 4;
        end
        offs = '{0, 1, 2, 2, 1, 3};
        ni   = (nv == 3) ? 3 : 6;
        for (int k = 0; k < nv; k++) begin
            recs[k] = corner_vertex(vr[k], vc[k], base + IDX_BITS'(k));
        end
        for (int k = 0; k < ni; k++) begin
            recs[nv + k]             = '{default: '0};
            recs[nv + k].kind        = usm_pkg::KIND_INDEX;
            recs[nv + k].index_value = base + IDX_BITS'(offs[k]);
        end
        recs[nv + ni - 1].last = 1'b1;
        for (int k = 0; k < nv + ni; k++) begin
            queue_expected(recs[k]);
        end
        vert_count = base + IDX_BITS'(nv);
        return nv + ni;
    endfunction

    // ---------------- clock, reset ----------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- record checker ----------------

    always @(posedge i_clk) begin
        t_mesh_rec want;
        if (i_rst_n && rec_bus.valid && rec_bus.ready) begin
            recs_seen = recs_seen + 1;
            if (pending_recs.size() == 0) begin
                $error("record beat with nothing expected, index_value %0d",
                       rec_bus.index_value);
                errors = errors + 1;
            end else begin
                want = pending_recs.pop_front();
                if (rec_bus.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, rec_bus.kind);
                    errors = errors + 1;
                end
                if (rec_bus.pos_x !== want.pos_x) begin
                    $error("pos_x: expected %0d, got %0d", want.pos_x, rec_bus.pos_x);
                    errors = errors + 1;
                end
                if (rec_bus.pos_y !== want.pos_y) begin
                    $error("pos_y: expected %0d, got %0d", want.pos_y, rec_bus.pos_y);
                    errors = errors + 1;
                end
                if (rec_bus.pos_z !== want.pos_z) begin
                    $error("pos_z: expected %0d, got %0d", want.pos_z, rec_bus.pos_z);
                    errors = errors + 1;
                end
                if (rec_bus.tex_u !== want.tex_u) begin
                    $error("tex_u: expected %0d, got %0d", want.tex_u, rec_bus.tex_u);
                    errors = errors + 1;
                end
                if (rec_bus.tex_v !== want.tex_v) begin
                    $error("tex_v: expected %0d, got %0d", want.tex_v, rec_bus.tex_v);
                    errors = errors + 1;
                end
                if (rec_bus.index_value !== want.index_value) begin
                    $error("index_value: expected %0d, got %0d", want.index_value,
                           rec_bus.index_value);
                    errors = errors + 1;
                end
                if (rec_bus.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, rec_bus.last);
                    errors = errors + 1;
                end
            end
        end
        // receiver back-pressure for the next cycle
        rec_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------- watchdog ----------------

    always @(posedge i_clk) begin
        if ((cell_bus.valid && cell_bus.ready) || (rec_bus.valid && rec_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= STALL_MAX) begin
            $display("no beat for %0d cycles, %0d records outstanding", STALL_MAX,
                     pending_recs.size());
            $display("[uv_sphere_mesh_generator] ERROR");
            $finish;
        end
    end

    // ---------------- drivers ----------------

    // One cell beat; prediction is made at the edge that takes it.
    task automatic send_cell(input int unsigned row, input int unsigned col, input bit restart,
                             output int n_recs);
        while ($urandom_range(99) < send_idle_pct) begin
            cell_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_bus.valid      <= 1'b1;
        cell_bus.stack_row  <= row[7:0];
        cell_bus.sector_col <= col[7:0];
        cell_bus.restart    <= restart;
        @(posedge i_clk);
        while (!cell_bus.ready) begin
            @(posedge i_clk);
        end
        n_recs      = predict_cell(row, col, restart);
        cells_taken = cells_taken + 1;
        if (n_recs == 0) begin
            off_grid = off_grid + 1;
        end
        if (restart) begin
            restarts = restarts + 1;
        end
    endtask

    task automatic wait_drained();
        cell_bus.valid <= 1'b0;
        while (pending_recs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Radius write; only called with the block idle.
    task automatic write_radius(input logic [15:0] value);
        wait_drained();
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) begin
            @(posedge i_clk);
        end
        cfg_bus.valid <= 1'b0;
        radius_q88 = value;
    endtask

    // Mostly grid cells, poles and edges favoured, some off-grid noise.
    task automatic send_random_cell();
        int unsigned row, col, pick;
        int          n;
        pick = $urandom_range(99);
        if (pick < 10) begin
            row = 0;
        end else if (pick < 20) begin
            row = N_STACK - 1;
        end else if (pick < 25) begin
            row = $urandom_range(255, N_STACK);
        end else begin
            row = $urandom_range(N_STACK - 1);
        end
        pick = $urandom_range(99);
        if (pick < 6) begin
            col = $urandom_range(255, N_SECT);
        end else if (pick < 14) begin
            col = N_SECT - 1;
        end else begin
            col = $urandom_range(N_SECT - 1);
        end
        send_cell(row, col, ($urandom_range(99) < 8), n);
    endtask

    // ---------------- sequence ----------------

    initial begin
        logic [15:0] radii[5];
        int          n;

        errors        = 0;
        cells_taken   = 0;
        recs_seen     = 0;
        off_grid      = 0;
        restarts      = 0;
        stall_cycles  = 0;
        send_idle_pct = 37;
        recv_idle_pct = 79;
        vert_count    = '0;
        radius_q88    = usm_pkg::RADIUS_RESET;

        i_rst_n             = 1'b0;
        cell_bus.valid      = 1'b0;
        cell_bus.stack_row  = '0;
        cell_bus.sector_col = '0;
        cell_bus.restart    = 1'b0;
        rec_bus.ready       = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.data        = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at the reset radius.
        foreach (directed_cells[i]) begin
            send_cell(directed_cells[i].row, directed_cells[i].col,
                      directed_cells[i].restart, n);
            if (n != directed_cells[i].n_recs) begin
                $error("records per cell: expected %0d, got %0d", directed_cells[i].n_recs, n);
                errors = errors + 1;
            end
        end

        // Random phases: both extremes of the radius first, then a random value, 1 and another random value.
        radii = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h0001, 16'($urandom)};
        for (int ph = 0; ph < 5; ph++) begin
            write_radius(radii[ph]);
            if (ph == 2) begin
                send_idle_pct = 79;
                recv_idle_pct = 37;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (PHASE_LEN) send_random_cell();
        end

        wait_drained();

        $display("%0d cells (%0d off grid, %0d restarts), %0d records checked",
                 cells_taken, off_grid, restarts, recs_seen);
        $display("radius swept over 0, 1, 65535, reset value and two random settings");
        if (errors == 0) begin
            $display("[uv_sphere_mesh_generator] OK");
        end else begin
            $display("[uv_sphere_mesh_generator] ERROR");
        end
        $finish;
    end

endmodule
